/* rtl/assert_macros.svh */
// Assertion helpers; clk and rst_n are taken from the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define PPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PPP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ppp_pkg.sv */
package ppp_pkg;

  localparam int FIELD_W     = 32;   // point, camera and screen fields
  localparam int ANG_W       = 16;   // angle register width
  localparam int VD_W        = 31;   // view distance
  localparam int CFG_IDX_W   = 4;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;

  // Internal datapath widths, from worst-case magnitudes.
  localparam int TRIG_W = 18;        // Q16 sine/cosine, -65536..65536
  localparam int XW     = 33;        // translated point
  localparam int AB_W   = 35;        // after yaw
  localparam int DE_W   = 35;        // after pitch
  localparam int DYZ_W  = 36;        // after roll
  localparam int MAG_W  = 36;        // magnitude of a camera-space value
  localparam int HALF_W = 18;        // split of MAG_W for the scale multiply
  localparam int PP_W   = VD_W + HALF_W;
  localparam int NUM_W  = VD_W + MAG_W;
  localparam int QW     = 64;        // quotient bits
  localparam int PRD_W  = 56;        // signed rotation products
  localparam int RW     = 66;        // signed result before clamping

  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_X         = 4'd0,
    REG_CAM_Y         = 4'd1,
    REG_CAM_Z         = 4'd2,
    REG_ANGLE_PITCH   = 4'd3,
    REG_ANGLE_ROLL    = 4'd4,
    REG_ANGLE_YAW     = 4'd5,
    REG_VIEW_DISTANCE = 4'd6,
    REG_SCREEN_OFFSET = 4'd7
  } cfg_reg_t;

  function automatic int out_width(input int coord_w);
    return (coord_w < FIELD_W) ? coord_w : FIELD_W;
  endfunction

endpackage

/* rtl/perspective_point_projector_unit.sv */
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall   | in_point_x, in_point_y, in_point_z
// out     | out | out_valid/out_stall | out_screen_x, out_screen_y,
//         |     |                     | out_depth_zero, out_overflowed
// cfg     | in  | cfg_we              | cfg_index, cfg_wdata
//
// One point per cycle unless in_stall is high; 9 rotation/scale stages, a divider
// load stage and 64 divider stages of one quotient bit each, one output register.
// The shared sine unit recomputes all six sine/cosine values after reset and after any angle write;
// in_stall stays high meanwhile.
// A stall on a valid output beat freezes the whole pipeline; in_stall follows it.
module perspective_point_projector_unit
  import ppp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [FIELD_W-1:0]   in_point_x,
  input  logic signed [FIELD_W-1:0]   in_point_y,
  input  logic signed [FIELD_W-1:0]   in_point_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [FIELD_W-1:0]   out_screen_x,
  output logic signed [FIELD_W-1:0]   out_screen_y,
  output logic                        out_depth_zero,
  output logic                        out_overflowed,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [FIELD_W-1:0]          cfg_wdata
);

  localparam int OUT_W = out_width(COORD_WIDTH);
  localparam logic signed [RW-1:0] MAXV = RW'((67'sd1 <<< (OUT_W - 1)) - 67'sd1);
  localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);
  localparam logic [QW-1:0]        QLIM = QW'(1) << (QW - 2);

  // ---------------- configuration registers ----------------
  logic signed [FIELD_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic [ANG_W-1:0]          pitch_r, roll_r, yaw_r;
  logic [VD_W-1:0]           vd_r;
  logic [FIELD_W-1:0]        offset_r;
  logic                      angle_wr;

  assign angle_wr = cfg_we &&
                    (cfg_index inside {REG_ANGLE_PITCH, REG_ANGLE_ROLL, REG_ANGLE_YAW});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r  <= '0;
      cam_y_r  <= '0;
      cam_z_r  <= '0;
      pitch_r  <= '0;
      roll_r   <= '0;
      yaw_r    <= '0;
      vd_r     <= VD_W'(65536);
      offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAM_X:         cam_x_r  <= cfg_wdata;
        REG_CAM_Y:         cam_y_r  <= cfg_wdata;
        REG_CAM_Z:         cam_z_r  <= cfg_wdata;
        REG_ANGLE_PITCH:   pitch_r  <= cfg_wdata[ANG_W-1:0];
        REG_ANGLE_ROLL:    roll_r   <= cfg_wdata[ANG_W-1:0];
        REG_ANGLE_YAW:     yaw_r    <= cfg_wdata[ANG_W-1:0];
        REG_VIEW_DISTANCE: vd_r     <= cfg_wdata[VD_W-1:0];
        REG_SCREEN_OFFSET: offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- sine/cosine sequencer ----------------
  // trig_r: sin yaw, cos yaw, sin pitch, cos pitch, sin roll, cos roll
  typedef enum logic [1:0] {TS_SQUARE, TS_CUBIC, TS_MID, TS_OUT} tstep_t;

  localparam int NTRIG = 6;

  tstep_t           step_r;
  logic             busy_r;
  logic [2:0]       idx_r;
  logic [16:0]      u_r, u2_r, t_r;
  logic             neg_r;
  trig_t            trig_r [NTRIG];
  logic [ANG_W-1:0] ang_sel;
  logic [15:0]      ph;
  logic [16:0]      u_new;
  logic [16:0]      mul_a, mul_b;
  logic [33:0]      prod;
  logic [17:0]      v;

  always_comb begin
    case (idx_r[2:1])
      2'd0:    ang_sel = yaw_r;
      2'd1:    ang_sel = pitch_r;
      default: ang_sel = roll_r;
    endcase
    ph = 16'(((32'(ang_sel) << 16) >> ANGLE_WIDTH)) + (idx_r[0] ? 16'd16384 : 16'd0);
    u_new = ph[14] ? {15'(15'd16384 - {1'b0, ph[13:0]}), 2'b00}
                   : {1'b0, ph[13:0], 2'b00};
    case (step_r)
      TS_SQUARE: begin mul_a = u_new;      mul_b = u_new; end
      TS_CUBIC:  begin mul_a = 17'd4640;   mul_b = u2_r;  end
      TS_MID:    begin mul_a = u2_r;       mul_b = t_r;   end
      default:   begin mul_a = u_r;        mul_b = t_r;   end
    endcase
    prod = 34'(mul_a) * 34'(mul_b);
    v    = prod[33:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      step_r <= TS_SQUARE;
    end else if (angle_wr) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      step_r <= TS_SQUARE;
    end else if (busy_r) begin
      case (step_r)
        TS_SQUARE: begin
          u_r    <= u_new;
          neg_r  <= ph[15];
          u2_r   <= prod[32:16];
          step_r <= TS_CUBIC;
        end
        TS_CUBIC: begin
          t_r    <= 17'd42048 - prod[32:16];
          step_r <= TS_MID;
        end
        TS_MID: begin
          t_r    <= 17'd102944 - prod[32:16];
          step_r <= TS_OUT;
        end
        default: begin
          trig_r[idx_r] <= neg_r ? -$signed(v) : $signed(v);
          step_r        <= TS_SQUARE;
          idx_r         <= idx_r + 3'd1;
          if (idx_r == 3'(NTRIG - 1)) busy_r <= 1'b0;
        end
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en || busy_r;

  // ---------------- rotation stages ----------------
  logic                    v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  logic signed [XW-1:0]    x1_r, y1_r, z1_r, z2_r, z3_r;
  logic signed [PRD_W-1:0] m2a_r, m2b_r, m2c_r, m2d_r;
  logic signed [AB_W-1:0]  a3_r, b3_r, b4_r, b5_r;
  logic signed [PRD_W-1:0] m4a_r, m4b_r, m4c_r, m4d_r;
  logic signed [DE_W-1:0]  dx5_r, e5_r, dx6_r;
  logic signed [PRD_W-1:0] m6a_r, m6b_r, m6c_r, m6d_r;
  logic signed [DYZ_W-1:0] dx7_r, dy7_r, dz7_r;
  logic [MAG_W-1:0]        mx8_r, my8_r, den8_r, den9_r;
  logic                    nx8_r, ny8_r, zero8_r, nx9_r, ny9_r, zero9_r;
  logic [PP_W-1:0]         pxl9_r, pxh9_r, pyl9_r, pyh9_r;

  logic signed [PRD_W-1:0] sum3a, sum3b, sum5a, sum5b, sum7a, sum7b;

  always_comb begin
    sum3a = m2a_r + m2b_r;
    sum3b = m2c_r - m2d_r;
    sum5a = m4a_r - m4b_r;
    sum5b = m4c_r + m4d_r;
    sum7a = m6a_r + m6b_r;
    sum7b = m6c_r - m6d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r} <= '0;
    end else if (en) begin
      v1_r <= in_valid && !busy_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // translate
      x1_r <= XW'(in_point_x) - XW'(cam_x_r);
      y1_r <= XW'(in_point_y) - XW'(cam_y_r);
      z1_r <= XW'(in_point_z) - XW'(cam_z_r);
      // yaw
      m2a_r <= PRD_W'(trig_r[0]) * PRD_W'(y1_r);
      m2b_r <= PRD_W'(trig_r[1]) * PRD_W'(x1_r);
      m2c_r <= PRD_W'(trig_r[1]) * PRD_W'(y1_r);
      m2d_r <= PRD_W'(trig_r[0]) * PRD_W'(x1_r);
      z2_r  <= z1_r;
      a3_r  <= AB_W'(sum3a >>> 16);
      b3_r  <= AB_W'(sum3b >>> 16);
      z3_r  <= z2_r;
      // pitch
      m4a_r <= PRD_W'(trig_r[3]) * PRD_W'(a3_r);
      m4b_r <= PRD_W'(trig_r[2]) * PRD_W'(z3_r);
      m4c_r <= PRD_W'(trig_r[3]) * PRD_W'(z3_r);
      m4d_r <= PRD_W'(trig_r[2]) * PRD_W'(a3_r);
      b4_r  <= b3_r;
      dx5_r <= DE_W'(sum5a >>> 16);
      e5_r  <= DE_W'(sum5b >>> 16);
      b5_r  <= b4_r;
      // roll
      m6a_r <= PRD_W'(trig_r[4]) * PRD_W'(e5_r);
      m6b_r <= PRD_W'(trig_r[5]) * PRD_W'(b5_r);
      m6c_r <= PRD_W'(trig_r[5]) * PRD_W'(e5_r);
      m6d_r <= PRD_W'(trig_r[4]) * PRD_W'(b5_r);
      dx6_r <= dx5_r;
      dx7_r <= DYZ_W'(dx6_r);
      dy7_r <= DYZ_W'(sum7a >>> 16);
      dz7_r <= DYZ_W'(sum7b >>> 16);
      // magnitudes and signs
      mx8_r   <= dx7_r[DYZ_W-1] ? MAG_W'(-dx7_r) : MAG_W'(dx7_r);
      my8_r   <= dy7_r[DYZ_W-1] ? MAG_W'(-dy7_r) : MAG_W'(dy7_r);
      den8_r  <= dz7_r[DYZ_W-1] ? MAG_W'(-dz7_r) : MAG_W'(dz7_r);
      nx8_r   <= dx7_r[DYZ_W-1] ^ dz7_r[DYZ_W-1];
      ny8_r   <= dy7_r[DYZ_W-1] ^ dz7_r[DYZ_W-1];
      zero8_r <= (dz7_r == '0);
      // scale by view distance in two partial products
      pxl9_r  <= PP_W'(vd_r) * PP_W'(mx8_r[HALF_W-1:0]);
      pxh9_r  <= PP_W'(vd_r) * PP_W'(mx8_r[MAG_W-1:HALF_W]);
      pyl9_r  <= PP_W'(vd_r) * PP_W'(my8_r[HALF_W-1:0]);
      pyh9_r  <= PP_W'(vd_r) * PP_W'(my8_r[MAG_W-1:HALF_W]);
      den9_r  <= den8_r;
      nx9_r   <= nx8_r;
      ny9_r   <= ny8_r;
      zero9_r <= zero8_r;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  logic [NUM_W-1:0] numx, numy;

  assign numx = NUM_W'(pxl9_r) + (NUM_W'(pxh9_r) << HALF_W);
  assign numy = NUM_W'(pyl9_r) + (NUM_W'(pyh9_r) << HALF_W);

  logic             dv_v    [QW+1];
  logic [MAG_W-1:0] dv_remx [QW+1];
  logic [MAG_W-1:0] dv_remy [QW+1];
  logic [QW-1:0]    dv_wx   [QW+1];
  logic [QW-1:0]    dv_wy   [QW+1];
  logic             dv_ox   [QW+1];
  logic             dv_oy   [QW+1];
  logic             dv_nx   [QW+1];
  logic             dv_ny   [QW+1];
  logic             dv_z    [QW+1];
  logic [MAG_W-1:0] dv_den  [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_remx[0] <= MAG_W'(numx[NUM_W-1:QW]);
      dv_remy[0] <= MAG_W'(numy[NUM_W-1:QW]);
      dv_wx[0]   <= numx[QW-1:0];
      dv_wy[0]   <= numy[QW-1:0];
      // quotient would not fit in the bits left
      dv_ox[0]   <= MAG_W'(numx[NUM_W-1:QW]) >= den9_r;
      dv_oy[0]   <= MAG_W'(numy[NUM_W-1:QW]) >= den9_r;
      dv_nx[0]   <= nx9_r;
      dv_ny[0]   <= ny9_r;
      dv_z[0]    <= zero9_r;
      dv_den[0]  <= den9_r;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [MAG_W:0] tx, ty;
    logic           gx, gy;

    assign tx = {dv_remx[k], dv_wx[k][QW-1]};
    assign ty = {dv_remy[k], dv_wy[k][QW-1]};
    assign gx = tx >= {1'b0, dv_den[k]};
    assign gy = ty >= {1'b0, dv_den[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_remx[k+1] <= gx ? MAG_W'(tx - {1'b0, dv_den[k]}) : MAG_W'(tx);
        dv_remy[k+1] <= gy ? MAG_W'(ty - {1'b0, dv_den[k]}) : MAG_W'(ty);
        dv_wx[k+1]   <= {dv_wx[k][QW-2:0], gx};
        dv_wy[k+1]   <= {dv_wy[k][QW-2:0], gy};
        dv_ox[k+1]   <= dv_ox[k];
        dv_oy[k+1]   <= dv_oy[k];
        dv_nx[k+1]   <= dv_nx[k];
        dv_ny[k+1]   <= dv_ny[k];
        dv_z[k+1]    <= dv_z[k];
        dv_den[k+1]  <= dv_den[k];
      end
    end
  end

  // ---------------- sign, offset, clamp ----------------
  logic signed [RW-1:0]    rx, ry, offx, offy;
  logic signed [RW-1:0]    fx, fy;
  logic                    sx, sy, ovfx, ovfy;
  logic signed [FIELD_W-1:0] sx_nxt, sy_nxt;
  logic                    ovf_nxt;

  always_comb begin
    offx = RW'($signed(offset_r[15:0])) <<< 8;
    offy = RW'($signed(offset_r[31:16])) <<< 8;
    rx   = (dv_nx[QW] ? -RW'(dv_wx[QW]) : RW'(dv_wx[QW])) - offx;
    ry   = (dv_ny[QW] ? -RW'(dv_wy[QW]) : RW'(dv_wy[QW])) - offy;
    sx   = dv_ox[QW] || (dv_wx[QW] > QLIM);
    sy   = dv_oy[QW] || (dv_wy[QW] > QLIM);
    if (sx)               begin fx = dv_nx[QW] ? MINV : MAXV; ovfx = 1'b1; end
    else if (rx > MAXV)   begin fx = MAXV;                    ovfx = 1'b1; end
    else if (rx < MINV)   begin fx = MINV;                    ovfx = 1'b1; end
    else                  begin fx = rx;                      ovfx = 1'b0; end
    if (sy)               begin fy = dv_ny[QW] ? MINV : MAXV; ovfy = 1'b1; end
    else if (ry > MAXV)   begin fy = MAXV;                    ovfy = 1'b1; end
    else if (ry < MINV)   begin fy = MINV;                    ovfy = 1'b1; end
    else                  begin fy = ry;                      ovfy = 1'b0; end
    // zero depth: drop the quotient
    sx_nxt  = dv_z[QW] ? '0 : fx[FIELD_W-1:0];
    sy_nxt  = dv_z[QW] ? '0 : fy[FIELD_W-1:0];
    ovf_nxt = !dv_z[QW] && (ovfx || ovfy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_screen_x   <= sx_nxt;
      out_screen_y   <= sy_nxt;
      out_depth_zero <= dv_z[QW];
      out_overflowed <= ovf_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/ppp_checker.sv */
`include "assert_macros.svh"

module ppp_checker
  import ppp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [FIELD_W-1:0] out_screen_x,
  input logic signed [FIELD_W-1:0] out_screen_y,
  input logic                      out_depth_zero,
  input logic                      out_overflowed
);

  localparam int OUT_W = out_width(COORD_WIDTH);
  localparam logic signed [FIELD_W-1:0] MAXV = FIELD_W'((33'sd1 <<< (OUT_W - 1)) - 33'sd1);
  localparam logic signed [FIELD_W-1:0] MINV = -MAXV - FIELD_W'(1);

  logic [7:0] cnt_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 8'(in_acc) - 8'(out_acc);
    end
  end

  `PPP_ASSERT_IMP(a_no_orphan, out_valid, cnt_r != 8'd0, "result beat with no point in flight")
  `PPP_ASSERT_IMP(a_zero_depth, out_valid && out_depth_zero,
                  out_screen_x == '0 && out_screen_y == '0 && !out_overflowed,
                  "zero depth beat carries coordinates or overflow")
  `PPP_ASSERT_IMP(a_ovf_clamped, out_valid && out_overflowed,
                  out_screen_x == MAXV || out_screen_x == MINV ||
                  out_screen_y == MAXV || out_screen_y == MINV,
                  "overflow flagged without a clamped coordinate")
  `PPP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_screen_x) && $stable(out_screen_y),
                   "stalled result beat changed")

endmodule

bind perspective_point_projector_unit ppp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ppp_checker (.*);
